### sv/sorted_timeout_queue_top_assert.svh
// Assertion macros for the sorted timeout queue.
// Expects clk_i and rst_ni in the scope where a macro is expanded.
`ifndef SORTED_TIMEOUT_QUEUE_TOP_ASSERT_SVH
`define SORTED_TIMEOUT_QUEUE_TOP_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define STQ_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check a consequence in the same cycle as its cause
`define STQ_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause
`define STQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/stq_pkg.sv
// Shared types and constants of the sorted timeout queue.
// No dependencies; used by the interfaces, the cell row and the top level.
package stq_pkg;

  localparam int unsigned TIME_W      = 64;
  localparam int unsigned DELAY_W     = 31;
  localparam int unsigned REM_W       = 32;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned ID_BITS_DEF = 16;

  // Largest reportable remaining time, and the answer for no match
  localparam logic [REM_W-1:0] REM_MAX  = {1'b0, {(REM_W-1){1'b1}}};
  localparam logic [REM_W-1:0] REM_NONE = {REM_W{1'b1}};

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_QUERY  = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_EXPIRED   = 3'd0,
    ST_ACCEPTED  = 3'd1,
    ST_REJECTED  = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  // Operation broadcast to every cell of the row
  typedef enum logic [1:0] {
    OP_HOLD         = 2'd0,
    OP_INSERT       = 2'd1,
    OP_REMOVE_MATCH = 2'd2,
    OP_REMOVE_HEAD  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e            op;
    logic [TIME_W-1:0]   dl;
    logic [TIME_W-1:0]   now;
  } cell_ctl_t;

  // Row summary seen by the sequencer
  typedef struct packed {
    logic any_match;
    logic head_due;
    logic next_due;
    logic full;
  } row_stat_t;

endpackage

### sv/stq_if.sv
// Request and response channel interfaces of the sorted timeout queue.
// Depends on stq_pkg for field widths.
interface stq_req_if #(
  parameter int unsigned ID_BITS = stq_pkg::ID_BITS_DEF
) ();
  import stq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [DELAY_W-1:0]   delay_ms;
  logic [ID_BITS-1:0]   subscriber_id;
  logic [ID_BITS-1:0]   command_id;

  modport source (
    output valid, req_type, delay_ms, subscriber_id, command_id,
    input  ready
  );
  modport sink (
    input  valid, req_type, delay_ms, subscriber_id, command_id,
    output ready
  );
endinterface

interface stq_rsp_if #(
  parameter int unsigned ID_BITS = stq_pkg::ID_BITS_DEF,
  parameter int unsigned DEPTH   = stq_pkg::DEPTH_DEF
) ();
  import stq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [ID_BITS-1:0]       out_subscriber;
  logic [ID_BITS-1:0]       out_command;
  logic signed [REM_W-1:0]  remaining_ms;
  logic [CNT_W-1:0]         removed_count;
  logic                     last;

  modport source (
    output valid, status, out_subscriber, out_command, remaining_ms, removed_count, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_subscriber, out_command, remaining_ms, removed_count, last,
    output ready
  );
endinterface

### sv/stq_cell.sv
// One slot of the deadline-sorted row: deadline, subscriber and command.
// Depends on stq_pkg; instantiated by stq_row.
module stq_cell #(
  parameter int unsigned ID_BITS = stq_pkg::ID_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stq_pkg::cell_ctl_t            ctl_i,
  input  logic [ID_BITS-1:0]            sub_i,
  input  logic [ID_BITS-1:0]            cmd_i,
  // left neighbor (closer to the head)
  input  logic                          l_lt_i,
  input  logic                          l_vld_i,
  input  logic [stq_pkg::TIME_W-1:0]    l_dl_i,
  input  logic [ID_BITS-1:0]            l_sub_i,
  input  logic [ID_BITS-1:0]            l_cmd_i,
  // right neighbor (closer to the tail)
  input  logic                          r_vld_i,
  input  logic [stq_pkg::TIME_W-1:0]    r_dl_i,
  input  logic [ID_BITS-1:0]            r_sub_i,
  input  logic [ID_BITS-1:0]            r_cmd_i,
  input  logic                          hit_i,
  output logic                          vld_o,
  output logic [stq_pkg::TIME_W-1:0]    dl_o,
  output logic [ID_BITS-1:0]            sub_o,
  output logic [ID_BITS-1:0]            cmd_o,
  output logic                          lt_o,
  output logic                          due_o,
  output logic                          match_o,
  output logic                          hit_o
);
  import stq_pkg::*;

  logic                vld_q, vld_d;
  logic [TIME_W-1:0]   dl_q, dl_d;
  logic [ID_BITS-1:0]  sub_q, sub_d;
  logic [ID_BITS-1:0]  cmd_q, cmd_d;

  // Local compares against the broadcast request
  assign lt_o    = vld_q && (dl_q < ctl_i.dl);
  assign due_o   = vld_q && (dl_q <= ctl_i.now);
  assign match_o = vld_q && (sub_q == sub_i) && (cmd_q == cmd_i);
  assign hit_o   = hit_i | match_o;

  // Keep, take the new entry, or shift from a neighbor
  always_comb begin
    vld_d = vld_q;
    dl_d  = dl_q;
    sub_d = sub_q;
    cmd_d = cmd_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (!lt_o) begin
          if (l_lt_i) begin
            vld_d = 1'b1;
            dl_d  = ctl_i.dl;
            sub_d = sub_i;
            cmd_d = cmd_i;
          end else begin
            vld_d = l_vld_i;
            dl_d  = l_dl_i;
            sub_d = l_sub_i;
            cmd_d = l_cmd_i;
          end
        end
      end
      OP_REMOVE_MATCH: begin
        if (hit_i | match_o) begin
          vld_d = r_vld_i;
          dl_d  = r_dl_i;
          sub_d = r_sub_i;
          cmd_d = r_cmd_i;
        end
      end
      OP_REMOVE_HEAD: begin
        vld_d = r_vld_i;
        dl_d  = r_dl_i;
        sub_d = r_sub_i;
        cmd_d = r_cmd_i;
      end
      default: begin
        vld_d = vld_q;
      end
    endcase
  end

  // Occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    dl_q  <= dl_d;
    sub_q <= sub_d;
    cmd_q <= cmd_d;
  end

  assign vld_o = vld_q;
  assign dl_o  = dl_q;
  assign sub_o = sub_q;
  assign cmd_o = cmd_q;

endmodule

### sv/stq_row.sv
// Row of timeout cells kept sorted by deadline, packed toward the head.
// Depends on stq_pkg, stq_cell and the assertion macro header.
`include "sorted_timeout_queue_top_assert.svh"

module stq_row #(
  parameter int unsigned DEPTH   = stq_pkg::DEPTH_DEF,
  parameter int unsigned ID_BITS = stq_pkg::ID_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  stq_pkg::cell_ctl_t          ctl_i,
  input  logic [ID_BITS-1:0]          sub_i,
  input  logic [ID_BITS-1:0]          cmd_i,
  output stq_pkg::row_stat_t          stat_o,
  output logic [stq_pkg::TIME_W-1:0]  sel_dl_o,
  output logic [ID_BITS-1:0]          head_sub_o,
  output logic [ID_BITS-1:0]          head_cmd_o
);
  import stq_pkg::*;

  logic [DEPTH-1:0]    vld, lt, due, match, hit, first;
  logic [TIME_W-1:0]   dl  [DEPTH];
  logic [ID_BITS-1:0]  sub [DEPTH];
  logic [ID_BITS-1:0]  cmd [DEPTH];
  logic                sorted;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                l_lt, l_vld, r_vld, hit_in;
    logic [TIME_W-1:0]   l_dl, r_dl;
    logic [ID_BITS-1:0]  l_sub, l_cmd, r_sub, r_cmd;

    // Head cell sees an always-earlier left side and no prior match
    if (i == 0) begin : g_head
      assign l_lt   = 1'b1;
      assign l_vld  = 1'b0;
      assign l_dl   = '0;
      assign l_sub  = '0;
      assign l_cmd  = '0;
      assign hit_in = 1'b0;
    end else begin : g_mid_l
      assign l_lt   = lt[i-1];
      assign l_vld  = vld[i-1];
      assign l_dl   = dl[i-1];
      assign l_sub  = sub[i-1];
      assign l_cmd  = cmd[i-1];
      assign hit_in = hit[i-1];
    end

    // Tail cell pulls in an empty slot
    if (i == DEPTH - 1) begin : g_tail
      assign r_vld = 1'b0;
      assign r_dl  = '0;
      assign r_sub = '0;
      assign r_cmd = '0;
    end else begin : g_mid_r
      assign r_vld = vld[i+1];
      assign r_dl  = dl[i+1];
      assign r_sub = sub[i+1];
      assign r_cmd = cmd[i+1];
    end

    assign first[i] = match[i] & ~hit_in;

    stq_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_i),
      .sub_i   (sub_i),
      .cmd_i   (cmd_i),
      .l_lt_i  (l_lt),
      .l_vld_i (l_vld),
      .l_dl_i  (l_dl),
      .l_sub_i (l_sub),
      .l_cmd_i (l_cmd),
      .r_vld_i (r_vld),
      .r_dl_i  (r_dl),
      .r_sub_i (r_sub),
      .r_cmd_i (r_cmd),
      .hit_i   (hit_in),
      .vld_o   (vld[i]),
      .dl_o    (dl[i]),
      .sub_o   (sub[i]),
      .cmd_o   (cmd[i]),
      .lt_o    (lt[i]),
      .due_o   (due[i]),
      .match_o (match[i]),
      .hit_o   (hit[i])
    );
  end

  // Deadline of the first matching entry
  always_comb begin
    sel_dl_o = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      sel_dl_o = sel_dl_o | (dl[i] & {TIME_W{first[i]}});
    end
  end

  // Row summary
  assign stat_o.any_match = hit[DEPTH-1];
  assign stat_o.head_due  = due[0];
  assign stat_o.next_due  = due[1];
  assign stat_o.full      = vld[DEPTH-1];
  assign head_sub_o       = sub[0];
  assign head_cmd_o       = cmd[0];

  // Ordering of neighboring valid entries
  always_comb begin
    sorted = 1'b1;
    for (int unsigned i = 0; i + 1 < DEPTH; i++) begin
      if (vld[i+1] && (dl[i] > dl[i+1])) begin
        sorted = 1'b0;
      end
    end
  end

  `STQ_ASSERT_ALWAYS(a_row_packed, (vld & (vld + DEPTH'(1))) == '0, "row has a hole")
  `STQ_ASSERT_ALWAYS(a_row_sorted, sorted, "row out of deadline order")
  `STQ_ASSERT_NEXT(a_row_insert_grows, ctl_i.op == OP_INSERT, $countones(vld) == ($past($countones(vld)) + 1), "insert did not add one entry")

endmodule

### sv/sorted_timeout_queue_top.sv
// Sorted timeout queue: millisecond clock, deadline-ordered timeout row and request sequencer.
// Depends on stq_pkg, stq_if, stq_row and the assertion macro header.
//
// The block accepts one request item at a time and takes the next one as soon as the
// final result of the current one sits in the output register, or in the cycle after that
// for a tick that expired entries. An add gives its result from the execute state, a query
// from the response state, a cancel once no matching entry is left, and a tick gives one
// result per expired entry; a tick with nothing due finishes without a result. The cell row
// removes one matching entry or shifts out one expired head per cycle, a head only while the
// result register is free, and the deadline select is registered ahead of the remaining-time
// subtract. Stalls on the result channel hold back each result. The row starts empty after
// reset, with no clearing pass.
`include "sorted_timeout_queue_top_assert.svh"

module sorted_timeout_queue_top #(
  parameter int unsigned DEPTH   = stq_pkg::DEPTH_DEF,
  parameter int unsigned ID_BITS = stq_pkg::ID_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stq_req_if.sink    req_i,
  stq_rsp_if.source  rsp_o
);
  import stq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_QRESP = 3'b100
  } state_e;

  state_e              state_q, state_d;
  req_e                type_q;
  logic [TIME_W-1:0]   now_q, dl_q, qdl_q;
  logic                qfound_q;
  logic [ID_BITS-1:0]  sub_q, cmd_q;
  logic [CNT_W-1:0]    cnt_q;

  logic                out_valid_q;
  status_e             out_status_q;
  logic [ID_BITS-1:0]  out_sub_q, out_cmd_q;
  logic [REM_W-1:0]    out_rem_q;
  logic [CNT_W-1:0]    out_cnt_q;
  logic                out_last_q;

  logic                req_accept, out_free, load, cnt_inc, qcap;
  status_e             ld_status;
  logic [ID_BITS-1:0]  ld_sub, ld_cmd;
  logic [REM_W-1:0]    ld_rem, rem_clamped;
  logic [CNT_W-1:0]    ld_cnt;
  logic                ld_last;
  logic [TIME_W:0]     rem_diff;

  cell_ctl_t           ctl;
  row_stat_t           stat;
  logic [TIME_W-1:0]   sel_dl;
  logic [ID_BITS-1:0]  head_sub, head_cmd;

  // Handshakes
  assign req_i.ready = (state_q == S_IDLE);
  assign req_accept  = req_i.valid & req_i.ready;
  assign out_free    = !out_valid_q | rsp_o.ready;

  // Remaining time of the selected entry, zero when past, saturated at the top
  assign rem_diff = {1'b0, qdl_q} - {1'b0, now_q};
  always_comb begin
    if (rem_diff[TIME_W] || (rem_diff[TIME_W-1:0] == '0)) begin
      rem_clamped = '0;
    end else if (|rem_diff[TIME_W-1:REM_W-1]) begin
      rem_clamped = REM_MAX;
    end else begin
      rem_clamped = rem_diff[REM_W-1:0];
    end
  end

  // Sequence the current item over the row
  always_comb begin
    state_d   = state_q;
    ctl.op    = OP_HOLD;
    ctl.dl    = dl_q;
    ctl.now   = now_q;
    load      = 1'b0;
    cnt_inc   = 1'b0;
    qcap      = 1'b0;
    ld_status = ST_ACCEPTED;
    ld_sub    = sub_q;
    ld_cmd    = cmd_q;
    ld_rem    = '0;
    ld_cnt    = '0;
    ld_last   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (req_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (type_q)
          REQ_TICK: begin
            if (!stat.head_due) begin
              state_d = S_IDLE;
            end else if (out_free) begin
              load      = 1'b1;
              ld_status = ST_EXPIRED;
              ld_sub    = head_sub;
              ld_cmd    = head_cmd;
              ld_last   = !stat.next_due;
              ctl.op    = OP_REMOVE_HEAD;
            end
          end
          REQ_ADD: begin
            if (out_free) begin
              load    = 1'b1;
              state_d = S_IDLE;
              if ((sub_q != '0) && !stat.full) begin
                ctl.op    = OP_INSERT;
                ld_status = ST_ACCEPTED;
              end else begin
                ld_status = ST_REJECTED;
              end
            end
          end
          REQ_CANCEL: begin
            if (stat.any_match) begin
              ctl.op  = OP_REMOVE_MATCH;
              cnt_inc = 1'b1;
            end else if (out_free) begin
              load      = 1'b1;
              ld_status = ST_CANCELLED;
              ld_cnt    = cnt_q;
              state_d   = S_IDLE;
            end
          end
          REQ_QUERY: begin
            qcap    = 1'b1;
            state_d = S_QRESP;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_QRESP: begin
        if (out_free) begin
          load      = 1'b1;
          ld_status = qfound_q ? ST_FOUND : ST_NOT_FOUND;
          ld_rem    = qfound_q ? rem_clamped : REM_NONE;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and clock
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (req_accept && (req_e'(req_i.req_type) == REQ_TICK)) begin
        now_q <= now_q + TIME_W'(1);
      end
      if (req_accept) begin
        cnt_q <= '0;
      end else if (cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the request, the query selection and the result
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      type_q <= req_e'(req_i.req_type);
      sub_q  <= req_i.subscriber_id;
      cmd_q  <= req_i.command_id;
      dl_q   <= now_q + TIME_W'(req_i.delay_ms);
    end
    if (qcap) begin
      qfound_q <= stat.any_match;
      qdl_q    <= sel_dl;
    end
    if (load) begin
      out_status_q <= ld_status;
      out_sub_q    <= ld_sub;
      out_cmd_q    <= ld_cmd;
      out_rem_q    <= ld_rem;
      out_cnt_q    <= ld_cnt;
      out_last_q   <= ld_last;
    end
  end

  stq_row #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_row (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .sub_i      (sub_q),
    .cmd_i      (cmd_q),
    .stat_o     (stat),
    .sel_dl_o   (sel_dl),
    .head_sub_o (head_sub),
    .head_cmd_o (head_cmd)
  );

  // Drive the result channel
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.out_subscriber = out_sub_q;
  assign rsp_o.out_command    = out_cmd_q;
  assign rsp_o.remaining_ms   = $signed(out_rem_q);
  assign rsp_o.removed_count  = out_cnt_q;
  assign rsp_o.last           = out_last_q;

  `STQ_ASSERT_IMP(a_head_due, ctl.op == OP_REMOVE_HEAD, stat.head_due, "expired a head that is not due")
  `STQ_ASSERT_IMP(a_cancel_clean, (state_q == S_EXEC) && (type_q == REQ_CANCEL) && (state_d == S_IDLE), !stat.any_match, "cancel finished with a match left")
  `STQ_ASSERT_NEXT(a_done_last, (state_q != S_IDLE) && (state_d == S_IDLE) && (type_q != REQ_TICK), out_valid_q && out_last_q, "request finished without a final result")

endmodule
